// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; take in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication: whenever cond holds, expr must hold in the same cycle
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

`endif

// ===== hdl/stks_pkg.sv =====
// Shared constants and helpers for the segmented top-k selector.
// No dependencies.
`default_nettype none

package stks_pkg;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 17;
   localparam int KEEP_W     = 5;
   localparam int KEEP_RESET = 16;

   localparam logic [VALUE_W-1:0]    PAD_VALUE    = '0;
   localparam logic [POSITION_W-1:0] PAD_POSITION = '1;

   // Map an IEEE single pattern to an unsigned key with the same order;
   // negative zero folds onto positive zero.
   function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] bits);
      logic [VALUE_W-1:0] b;
      b = (bits == 32'h8000_0000) ? '0 : bits;
      if (b[VALUE_W-1]) begin
         return ~b;
      end
      return b | 32'h8000_0000;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/segment_top_k_select.sv =====
// Segmented top-k selector: keeps the k largest values of each segment.
// Uses stks_pkg.
//
// Usage:
//  - req channel: one sample per request (sample_value, segment_end,
//    empty_segment). The sample insert is done in the accepting cycle by a
//    parallel compare-and-shift over K_MAX kept entries, so one request per
//    cycle is taken while req_stall is low.
//  - At a closing request (segment_end or empty_segment) the sorted entries,
//    padded to k (only padding for empty_segment), are copied into an output
//    shift buffer and k responses follow, one per cycle while rsp_stall is
//    low, the first in the cycle after the request; the last has run_last set.
//  - Plain samples are taken every cycle, also while a buffer drains. A
//    closing request is stalled only while the previous k responses are
//    still being drained, so back-to-back segments of at least k samples
//    run at one sample per cycle while rsp_stall stays low.
//  - csr_write_data sets k (0 acts as 1, above K_MAX as K_MAX); write only
//    while idle.
//  - Reset (synchronous, active high) empties the kept set, the position
//    counter and the output buffer; k returns to 16.
//  - rsp_stall holds the current response; the buffer does not advance.
`default_nettype none

module segment_top_k_select #(
   parameter int K_MAX         = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [stks_pkg::KEEP_W-1:0]       csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [stks_pkg::VALUE_W-1:0]      req_sample_value,
   input  wire logic                              req_segment_end,
   input  wire logic                              req_empty_segment,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [stks_pkg::VALUE_W-1:0]           rsp_top_value,
   output logic signed [stks_pkg::POSITION_W-1:0] rsp_top_position,
   output logic                                   rsp_run_last,
   output logic                                   rsp_position_saturated
);
   import stks_pkg::*;

   localparam int CW = $clog2(K_MAX + 1);
   localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Configuration
   logic [KEEP_W-1:0] keep_count_ff;
   logic [CW-1:0]     k_eff;

   // Kept set
   logic [VALUE_W-1:0]       kept_val_ff [K_MAX];
   logic [POSITION_BITS-1:0] kept_pos_ff [K_MAX];
   logic [VALUE_W-1:0]       kept_val_in [K_MAX];
   logic [POSITION_BITS-1:0] kept_pos_in [K_MAX];
   logic [CW-1:0]            kept_total_ff, kept_total_in;

   // Position tracking
   logic [POSITION_BITS-1:0] elem_pos_ff, elem_pos_in;
   logic                     max_taken_ff, max_taken_in;
   logic                     overflow_ff, overflow_in;
   logic [POSITION_BITS-1:0] cur_pos;

   // Output buffer
   logic [VALUE_W-1:0]    buf_val_ff [K_MAX];
   logic [POSITION_W-1:0] buf_pos_ff [K_MAX];
   logic [VALUE_W-1:0]    buf_val_in [K_MAX];
   logic [POSITION_W-1:0] buf_pos_in [K_MAX];
   logic [CW-1:0]         remain_ff, remain_in;
   logic                  sat_ff, sat_in;

   logic             closing, buf_free, req_take, rsp_take;
   logic [CW-1:0]    n_held, n_out;
   logic [K_MAX-1:0] ge;
   logic [IW-1:0]    k_last;
   logic             do_insert;
   logic [VALUE_W-1:0] new_key;

   // Effective k
   always_comb begin
      if (keep_count_ff == '0) begin
         k_eff = CW'(1);
      end else if (int'(keep_count_ff) > K_MAX) begin
         k_eff = CW'(K_MAX);
      end else begin
         k_eff = CW'(keep_count_ff);
      end
   end

   // Handshake
   assign closing   = req_segment_end | req_empty_segment;
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign buf_free  = (remain_ff == '0) || (remain_ff == CW'(1) && ~rsp_stall);
   assign req_stall = closing & ~buf_free;
   assign req_take  = req_valid & ~req_stall;

   // Position of this sample
   assign cur_pos = max_taken_ff ? POS_MAX : elem_pos_ff;

   // Parallel compare against held entries
   assign n_held  = (kept_total_ff < k_eff) ? kept_total_ff : k_eff;
   assign new_key = order_key(req_sample_value);
   always_comb begin
      for (int j = 0; j < K_MAX; j++) begin
         ge[j] = (CW'(j) < n_held) && (order_key(kept_val_ff[j]) >= new_key);
      end
   end
   assign k_last    = IW'(k_eff - CW'(1));
   assign do_insert = !(n_held == k_eff && ge[k_last]);

   // Shifted insert
   always_comb begin
      for (int j = 0; j < K_MAX; j++) begin
         if (ge[j] || !do_insert) begin
            kept_val_in[j] = kept_val_ff[j];
            kept_pos_in[j] = kept_pos_ff[j];
         end else if (j == 0 || ge[(j == 0) ? 0 : j-1]) begin
            kept_val_in[j] = req_sample_value;
            kept_pos_in[j] = cur_pos;
         end else begin
            kept_val_in[j] = kept_val_ff[(j == 0) ? 0 : j-1];
            kept_pos_in[j] = kept_pos_ff[(j == 0) ? 0 : j-1];
         end
      end
      // a rejected sample leaves the held count as it is
      if (!do_insert) begin
         kept_total_in = kept_total_ff;
      end else if (n_held == k_eff) begin
         kept_total_in = k_eff;
      end else begin
         kept_total_in = n_held + CW'(1);
      end
   end

   // Position counter next values
   always_comb begin
      elem_pos_in  = elem_pos_ff;
      max_taken_in = max_taken_ff;
      overflow_in  = overflow_ff;
      if (max_taken_ff) begin
         overflow_in = 1'b1;
      end else if (elem_pos_ff == POS_MAX) begin
         max_taken_in = 1'b1;
      end else begin
         elem_pos_in = elem_pos_ff + POSITION_BITS'(1);
      end
   end

   // Output buffer load and shift
   assign n_out = (kept_total_in < k_eff) ? kept_total_in : k_eff;
   always_comb begin
      for (int r = 0; r < K_MAX; r++) begin
         buf_val_in[r] = buf_val_ff[r];
         buf_pos_in[r] = buf_pos_ff[r];
      end
      remain_in = remain_ff;
      sat_in    = sat_ff;
      if (rsp_take) begin
         for (int r = 0; r < K_MAX - 1; r++) begin
            buf_val_in[r] = buf_val_ff[r+1];
            buf_pos_in[r] = buf_pos_ff[r+1];
         end
         remain_in = remain_ff - CW'(1);
      end
      if (req_take && closing) begin
         for (int r = 0; r < K_MAX; r++) begin
            if (!req_empty_segment && CW'(r) < n_out) begin
               buf_val_in[r] = kept_val_in[r];
               buf_pos_in[r] = POSITION_W'(kept_pos_in[r]);
            end else begin
               buf_val_in[r] = PAD_VALUE;
               buf_pos_in[r] = PAD_POSITION;
            end
         end
         remain_in = k_eff;
         sat_in    = req_empty_segment ? 1'b0 : (overflow_ff | max_taken_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= KEEP_W'(KEEP_RESET);
         kept_total_ff <= '0;
         elem_pos_ff   <= '0;
         max_taken_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         remain_ff     <= '0;
         sat_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            keep_count_ff <= csr_write_data;
         end
         remain_ff <= remain_in;
         sat_ff    <= sat_in;
         if (req_take && !req_empty_segment) begin
            if (req_segment_end) begin
               kept_total_ff <= '0;
               elem_pos_ff   <= '0;
               max_taken_ff  <= 1'b0;
               overflow_ff   <= 1'b0;
            end else begin
               kept_total_ff <= kept_total_in;
               elem_pos_ff   <= elem_pos_in;
               max_taken_ff  <= max_taken_in;
               overflow_ff   <= overflow_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take && !req_empty_segment) begin
         for (int j = 0; j < K_MAX; j++) begin
            kept_val_ff[j] <= kept_val_in[j];
            kept_pos_ff[j] <= kept_pos_in[j];
         end
      end
      for (int r = 0; r < K_MAX; r++) begin
         buf_val_ff[r] <= buf_val_in[r];
         buf_pos_ff[r] <= buf_pos_in[r];
      end
   end

   // Response port
   assign rsp_valid              = (remain_ff != '0);
   assign rsp_top_value          = buf_val_ff[0];
   assign rsp_top_position       = buf_pos_ff[0];
   assign rsp_run_last           = (remain_ff == CW'(1));
   assign rsp_position_saturated = sat_ff;

endmodule

`default_nettype wire

// ===== hdl/stks_checker.sv =====
// Port-level checks for segment_top_k_select, bound into that module.
// Uses assert_macros.svh and stks_pkg.
`default_nettype none
`include "assert_macros.svh"

module stks_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [stks_pkg::VALUE_W-1:0]      rsp_top_value,
   input wire logic signed [stks_pkg::POSITION_W-1:0] rsp_top_position,
   input wire logic                              rsp_run_last,
   input wire logic                              rsp_position_saturated
);
   import stks_pkg::*;

   logic mid_run;
   assign mid_run = rsp_valid & ~rsp_stall & ~rsp_run_last;

   // A stalled response holds
   `ASSERT_CLK(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_value) && $stable(rsp_top_position), "stalled response changed")

   // A run drains without gaps
   `ASSERT_CLK(a_no_gap, clock, reset, mid_run |=> rsp_valid, "gap inside a response run")

   // Saturation flag is constant within a run
   `ASSERT_CLK(a_sat_run, clock, reset, mid_run |=> $stable(rsp_position_saturated), "saturation flag changed within a run")

   // Padding carries value zero
   `ASSERT_IMPL(a_pad, clock, reset, rsp_valid && rsp_top_position == PAD_POSITION, rsp_top_value == PAD_VALUE, "padding with nonzero value")

endmodule

bind segment_top_k_select stks_checker u_stks_checker (.*);

`default_nettype wire
